@@ design/tts_pkg.sv @@
// Shared types and constants for the timer table scheduler.
// Used by tts_front, tts_back and timer_table_scheduler_top; no dependencies.
package tts_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_SCAN   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RP_FIRE = 2'd0,
		RP_ADD  = 2'd1,
		RP_ACK  = 2'd2,
		RP_DONE = 2'd3
	} reply_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] id;
		logic [31:0] period;
		logic        rep;
		logic [47:0] now;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] period;
		logic        rep;
		logic [47:0] start;
	} entry_t;

endpackage

@@ design/timer_table_scheduler_top.sv @@
// Timer table scheduler, top level: front end queue plus table executor.
// Add, remove and clear each give one result once the back end takes them.
// A scan walks the sorted table one stored timer at a time, bound by the
// one shared elapsed-time and compare unit.
// Two commands can be queued; busy is high while the queue is full.
// Reset is asynchronous active low; it empties the table and sets lead time to 0.
module timer_table_scheduler_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [15:0] timer_id,
	input  logic [31:0] task_interval,
	input  logic        repeat_req,
	input  logic [47:0] now_time,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        res_valid,
	output logic [1:0]  reply,
	output logic [15:0] out_id,
	output logic [31:0] min_wait,
	output logic        none_pending,
	output logic        last
);

	tts_pkg::head_t head;
	logic           pop;

	assign cfg_ready = 1'b1;

	tts_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.kind          (kind),
		.timer_id      (timer_id),
		.task_interval (task_interval),
		.repeat_req    (repeat_req),
		.now_time      (now_time),
		.busy          (busy),
		.head          (head),
		.pop           (pop)
	);

	tts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.res_valid    (res_valid),
		.reply        (reply),
		.out_id       (out_id),
		.min_wait     (min_wait),
		.none_pending (none_pending),
		.last         (last)
	);

endmodule

@@ design/tts_front.sv @@
// Front end: accepts commands, decodes the kind and queues them for the back end.
// Depends on tts_pkg.
module tts_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          kind,
	input  logic [15:0]         timer_id,
	input  logic [31:0]         task_interval,
	input  logic                repeat_req,
	input  logic [47:0]         now_time,
	output logic                busy,
	output tts_pkg::head_t      head,
	input  logic                pop
);

	tts_pkg::cmd_t             mem_q [tts_pkg::QDEPTH];
	logic [tts_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [tts_pkg::QCNT_W-1:0] cnt_q;
	logic                       push;
	tts_pkg::cmd_t             cmd_in;

	assign busy = (cnt_q == tts_pkg::QCNT_W'(tts_pkg::QDEPTH));
	assign push = start && !busy;

	always_comb begin
		cmd_in.op     = tts_pkg::op_t'(kind);
		cmd_in.id     = timer_id;
		cmd_in.period = task_interval;
		cmd_in.rep    = repeat_req;
		cmd_in.now    = now_time;
	end

	assign head.valid = (cnt_q != '0);
	assign head.cmd   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_inc(push) - QCNT_inc(pop);
		end
	end

	function automatic logic [tts_pkg::QCNT_W-1:0] QCNT_inc(input logic b);
		QCNT_inc = {{(tts_pkg::QCNT_W-1){1'b0}}, b};
	endfunction

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("queue popped while empty");

endmodule

@@ design/tts_back.sv @@
// Back end: the timer table, kept sorted by id, and the command executor.
// Depends on tts_pkg.
module tts_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tts_pkg::head_t      head,
	output logic                pop,
	input  logic                cfg_valid,
	input  logic [15:0]         cfg_data,
	output logic                res_valid,
	output logic [1:0]          reply,
	output logic [15:0]         out_id,
	output logic [31:0]         min_wait,
	output logic                none_pending,
	output logic                last
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXEC   = 4'b0010,
		ST_SCAN_A = 4'b0100,
		ST_SCAN_B = 4'b1000
	} state_t;

	state_t                     state_q;
	tts_pkg::cmd_t             cmd_q;
	tts_pkg::entry_t           tab_q [tts_pkg::SLOTS];
	tts_pkg::entry_t           tab_d [tts_pkg::SLOTS];
	tts_pkg::entry_t           up_v  [tts_pkg::SLOTS];
	tts_pkg::entry_t           dn_v  [tts_pkg::SLOTS];
	tts_pkg::entry_t           new_ent, cur;
	logic [tts_pkg::CNT_W-1:0] cnt_q, cnt_d, i_q;
	logic [47:0]                elapsed_q;
	logic [31:0]                minw_q, wait_v;
	logic [15:0]                lead_q;
	logic [tts_pkg::SLOTS-1:0]  lt_v, lt_prev, hit_v, ge_v, dn_mask;
	logic                       dup, add_ok, fire, scan_end, do_add;

	logic                       res_valid_q, none_q, last_q;
	tts_pkg::reply_t           reply_q;
	logic [15:0]                id_q;
	logic [31:0]                wait_q;

	assign pop = (state_q == ST_IDLE) && head.valid;

	always_comb begin
		for (int j = 0; j < tts_pkg::SLOTS; j++) begin
			lt_v[j]  = (tts_pkg::CNT_W'(j) < cnt_q) && (tab_q[j].id < cmd_q.id);
			hit_v[j] = (tts_pkg::CNT_W'(j) < cnt_q) && (tab_q[j].id == cmd_q.id);
			ge_v[j]  = (tts_pkg::CNT_W'(j) < cnt_q) && (tab_q[j].id >= cmd_q.id);
		end
		lt_prev[0] = 1'b1;
		for (int j = 1; j < tts_pkg::SLOTS; j++) begin
			lt_prev[j] = lt_v[j-1];
		end
	end

	assign dup    = |hit_v;
	assign add_ok = (cmd_q.id != '0) && (cmd_q.period != '0) && !dup
		&& (cnt_q < tts_pkg::CNT_W'(tts_pkg::SLOTS));
	assign do_add = (state_q == ST_EXEC) && (cmd_q.op == tts_pkg::OP_ADD) && add_ok;

	assign cur      = tab_q[i_q[tts_pkg::IDX_W-1:0]];
	assign fire     = ({1'b0, elapsed_q} + 49'(lead_q)) >= 49'(cur.period);
	assign wait_v   = fire ? cur.period : (cur.period - elapsed_q[31:0]);
	assign scan_end = (i_q >= cnt_q);

	always_comb begin
		new_ent.id     = cmd_q.id;
		new_ent.period = cmd_q.period;
		new_ent.rep    = cmd_q.rep;
		new_ent.start  = cmd_q.now;
		up_v[0] = new_ent;
		for (int j = 1; j < tts_pkg::SLOTS; j++) begin
			up_v[j] = tab_q[j-1];
		end
		for (int j = 0; j < tts_pkg::SLOTS - 1; j++) begin
			dn_v[j] = tab_q[j+1];
		end
		dn_v[tts_pkg::SLOTS-1] = tab_q[tts_pkg::SLOTS-1];
	end

	// Entries above a removed one move down a place; an insert moves the
	// entries with larger ids up a place so the table stays sorted.
	always_comb begin
		tab_d   = tab_q;
		cnt_d   = cnt_q;
		dn_mask = '0;
		unique case (state_q)
			ST_EXEC: begin
				unique case (cmd_q.op)
					tts_pkg::OP_ADD: begin
						if (add_ok) begin
							cnt_d = cnt_q + 1'b1;
						end
					end
					tts_pkg::OP_REMOVE: begin
						if (dup) begin
							dn_mask = ge_v;
							cnt_d   = cnt_q - 1'b1;
						end
					end
					tts_pkg::OP_CLEAR: cnt_d = '0;
					default: ;
				endcase
			end
			ST_SCAN_B: begin
				if (fire && !cur.rep) begin
					for (int j = 0; j < tts_pkg::SLOTS; j++) begin
						dn_mask[j] = (tts_pkg::CNT_W'(j) >= i_q);
					end
					cnt_d = cnt_q - 1'b1;
				end else if (fire) begin
					tab_d[i_q[tts_pkg::IDX_W-1:0]].start = cmd_q.now;
				end
			end
			default: ;
		endcase
		for (int j = 0; j < tts_pkg::SLOTS; j++) begin
			if (do_add && !lt_v[j]) begin
				tab_d[j] = lt_prev[j] ? new_ent : up_v[j];
			end else if (dn_mask[j]) begin
				tab_d[j] = dn_v[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		tab_q <= tab_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			cnt_q       <= '0;
			i_q         <= '0;
			elapsed_q   <= '0;
			minw_q      <= '1;
			lead_q      <= '0;
			res_valid_q <= 1'b0;
			reply_q     <= tts_pkg::RP_FIRE;
			id_q        <= '0;
			wait_q      <= '0;
			none_q      <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			cnt_q       <= cnt_d;
			if (cfg_valid) begin
				lead_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						cmd_q <= head.cmd;
						if (head.cmd.op == tts_pkg::OP_SCAN) begin
							i_q     <= '0;
							minw_q  <= '1;
							state_q <= ST_SCAN_A;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					res_valid_q <= 1'b1;
					wait_q      <= '0;
					none_q      <= 1'b0;
					last_q      <= 1'b1;
					if (cmd_q.op == tts_pkg::OP_ADD) begin
						reply_q <= tts_pkg::RP_ADD;
						id_q    <= add_ok ? cmd_q.id : 16'd0;
					end else begin
						reply_q <= tts_pkg::RP_ACK;
						id_q    <= '0;
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN_A: begin
					if (scan_end) begin
						res_valid_q <= 1'b1;
						reply_q     <= tts_pkg::RP_DONE;
						id_q        <= '0;
						wait_q      <= minw_q;
						none_q      <= (cnt_q == '0);
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						elapsed_q <= (cmd_q.now >= cur.start) ? (cmd_q.now - cur.start) : 48'd0;
						state_q   <= ST_SCAN_B;
					end
				end
				ST_SCAN_B: begin
					if (fire) begin
						res_valid_q <= 1'b1;
						reply_q     <= tts_pkg::RP_FIRE;
						id_q        <= cur.id;
						wait_q      <= '0;
						none_q      <= 1'b0;
						last_q      <= 1'b0;
					end
					// A fired one-shot timer leaves the table; the next entry
					// slides into the current index.
					if (!(fire && !cur.rep)) begin
						i_q <= i_q + 1'b1;
						if (wait_v < minw_q) begin
							minw_q <= wait_v;
						end
					end
					state_q <= ST_SCAN_A;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid    = res_valid_q;
	assign reply        = reply_q;
	assign out_id       = id_q;
	assign min_wait     = wait_q;
	assign none_pending = none_q;
	assign last         = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= tts_pkg::CNT_W'(tts_pkg::SLOTS))
		else $error("timer count exceeds table size");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (reply_q == tts_pkg::RP_FIRE) |-> !last_q)
		else $error("fire result marked as last");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_B) |-> (i_q < cnt_q))
		else $error("scan index beyond table");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q != ST_IDLE))
		else $error("command popped but not started");

endmodule
